// ===== src/display_window_pixel_writer_defines.svh =====
// Assertion macros for the display window pixel writer.
`ifndef DISPLAY_WINDOW_PIXEL_WRITER_DEFINES_SVH
`define DISPLAY_WINDOW_PIXEL_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DWPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DWPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dwpw_pkg.sv =====
// Shared types and constants for the display window pixel writer.
package dwpw_pkg;

  // Panel size
  localparam int unsigned PANEL_COLS = 128;
  localparam int unsigned PANEL_ROWS = 160;

  // Command codes
  localparam logic [7:0] CMD_COL_WINDOW = 8'h2A;
  localparam logic [7:0] CMD_ROW_WINDOW = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  // Window register reset values
  localparam logic [15:0] COL_END_RST = 16'd127;
  localparam logic [15:0] ROW_END_RST = 16'd159;

  // Last window parameter byte
  localparam logic [1:0] PARAM_LAST = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_COL  = 2'd1,
    MODE_ROW  = 2'd2,
    MODE_MEM  = 2'd3
  } mode_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
  } out_pix_t;

  typedef struct packed {
    mode_t mode;
    logic  byte_phase;
  } core_status_t;

endpackage

// ===== src/dwpw_in_reg.sv =====
// Input register stage: holds one accepted request until the core takes it.
module dwpw_in_reg
  import dwpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  in_req_t in_req,
  input  logic    take,
  output logic    held_valid,
  output in_req_t held_req
);

  logic    in_v_r;
  logic    in_v_nxt;
  in_req_t in_req_r;
  logic    load;

  // Stall only while full and the core does not take the held request
  assign in_stall = in_v_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (load) begin
      in_v_nxt = 1'b1;
    end else if (take) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      in_req_r <= in_req;
    end
  end

  assign held_valid = in_v_r;
  assign held_req   = in_req_r;

endmodule

// ===== src/dwpw_core.sv =====
// Command decode, window registers, pixel assembly and cursor stepping.
module dwpw_core
  import dwpw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  in_req_t      req,
  output logic         emit,
  output out_pix_t     pix,
  output core_status_t status
);

  mode_t       mode_r,       mode_nxt;
  logic [1:0]  param_idx_r,  param_idx_nxt;
  logic [15:0] col_start_r,  col_start_nxt;
  logic [15:0] col_end_r,    col_end_nxt;
  logic [15:0] row_start_r,  row_start_nxt;
  logic [15:0] row_end_r,    row_end_nxt;
  logic [15:0] cursor_x_r,   cursor_x_nxt;
  logic [15:0] cursor_y_r,   cursor_y_nxt;
  logic [7:0]  high_byte_r,  high_byte_nxt;
  logic        byte_phase_r, byte_phase_nxt;

  logic        on_panel;
  logic        pixel_done;

  assign on_panel   = (cursor_x_r < 16'(PANEL_COLS)) && (cursor_y_r < 16'(PANEL_ROWS));
  assign pixel_done = step && req.is_data && (mode_r == MODE_MEM) && byte_phase_r;

  // Next state
  always_comb begin
    mode_nxt       = mode_r;
    param_idx_nxt  = param_idx_r;
    col_start_nxt  = col_start_r;
    col_end_nxt    = col_end_r;
    row_start_nxt  = row_start_r;
    row_end_nxt    = row_end_r;
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    high_byte_nxt  = high_byte_r;
    byte_phase_nxt = byte_phase_r;
    if (step && !req.is_data) begin
      // Any command restarts parameter and pixel pairing
      byte_phase_nxt = 1'b0;
      param_idx_nxt  = 2'd0;
      case (req.byte_value)
        CMD_COL_WINDOW: mode_nxt = MODE_COL;
        CMD_ROW_WINDOW: mode_nxt = MODE_ROW;
        CMD_MEM_WRITE: begin
          mode_nxt     = MODE_MEM;
          cursor_x_nxt = col_start_r;
          cursor_y_nxt = row_start_r;
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end else if (step) begin
      case (mode_r)
        MODE_COL, MODE_ROW: begin
          // Bytes arrive start hi, start lo, end hi, end lo
          if (mode_r == MODE_COL) begin
            case (param_idx_r)
              2'd0:    col_start_nxt[15:8] = req.byte_value;
              2'd1:    col_start_nxt[7:0]  = req.byte_value;
              2'd2:    col_end_nxt[15:8]   = req.byte_value;
              default: col_end_nxt[7:0]    = req.byte_value;
            endcase
          end else begin
            case (param_idx_r)
              2'd0:    row_start_nxt[15:8] = req.byte_value;
              2'd1:    row_start_nxt[7:0]  = req.byte_value;
              2'd2:    row_end_nxt[15:8]   = req.byte_value;
              default: row_end_nxt[7:0]    = req.byte_value;
            endcase
          end
          if (param_idx_r == PARAM_LAST) begin
            param_idx_nxt = 2'd0;
            mode_nxt      = MODE_IDLE;
          end else begin
            param_idx_nxt = param_idx_r + 2'd1;
          end
        end
        MODE_MEM: begin
          if (!byte_phase_r) begin
            high_byte_nxt  = req.byte_value;
            byte_phase_nxt = 1'b1;
          end else begin
            byte_phase_nxt = 1'b0;
            // Step along the line, wrap to next row, wrap window
            if (cursor_x_r >= col_end_r) begin
              cursor_x_nxt = col_start_r;
              if (cursor_y_r >= row_end_r) begin
                cursor_y_nxt = row_start_r;
              end else begin
                cursor_y_nxt = cursor_y_r + 16'd1;
              end
            end else begin
              cursor_x_nxt = cursor_x_r + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Outputs
  always_comb begin
    emit            = pixel_done && on_panel;
    pix.pixel_x     = cursor_x_r[7:0];
    pix.pixel_y     = cursor_y_r[7:0];
    pix.pixel_color = {high_byte_r, req.byte_value};
    status.mode       = mode_r;
    status.byte_phase = byte_phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      param_idx_r  <= 2'd0;
      col_start_r  <= 16'd0;
      col_end_r    <= COL_END_RST;
      row_start_r  <= 16'd0;
      row_end_r    <= ROW_END_RST;
      cursor_x_r   <= 16'd0;
      cursor_y_r   <= 16'd0;
      high_byte_r  <= 8'd0;
      byte_phase_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      param_idx_r  <= param_idx_nxt;
      col_start_r  <= col_start_nxt;
      col_end_r    <= col_end_nxt;
      row_start_r  <= row_start_nxt;
      row_end_r    <= row_end_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      high_byte_r  <= high_byte_nxt;
      byte_phase_r <= byte_phase_nxt;
    end
  end

endmodule

// ===== src/dwpw_out_reg.sv =====
// Result register: holds one pixel until the receiver takes it.
module dwpw_out_reg
  import dwpw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  out_pix_t push_pix,
  output logic     ready,
  output logic     out_valid,
  input  logic     out_stall,
  output out_pix_t out_pix
);

  logic     out_v_r;
  logic     out_v_nxt;
  out_pix_t out_pix_r;

  // Room when empty or draining this cycle
  assign ready = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt = out_v_r;
    if (push) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_pix_r <= push_pix;
    end
  end

  assign out_valid = out_v_r;
  assign out_pix   = out_pix_r;

endmodule

// ===== src/display_window_pixel_writer.sv =====
// Top level of the display window pixel writer.
//
// Input channel (in_valid / in_stall / in_req) carries one link byte per
// request, tagged command or data. Window commands take four data bytes;
// memory write pairs data bytes into 16-bit pixels placed at a cursor that
// walks the column/row window. Output channel (out_valid / out_stall /
// out_pix) carries one pixel with its x/y position; off-panel pixels and
// all non-pixel bytes produce nothing.
// A request is accepted into the input register, decoded by the core while
// held, and its pixel captured in the result register that drives out_pix.
// Throughput: one request per cycle while the result register has room,
// set by single input and result registers around decode and cursor logic.
// Reset (rst_n low, synchronous) empties both registers, selects no command
// and restores the window to the full panel with the cursor at the origin.
// When the receiver stalls with a pixel waiting, the held request stays in
// the input register and in_stall rises once that register is also full.
`include "display_window_pixel_writer_defines.svh"
module display_window_pixel_writer
  import dwpw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_pix_t out_pix
);

  logic         held_valid;
  in_req_t      held_req;
  logic         out_ready;
  logic         step;
  logic         emit;
  out_pix_t     core_pix;
  core_status_t status;

  // Held request advances whenever the result register has room
  assign step = held_valid && out_ready;

  dwpw_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .take       (step),
    .held_valid (held_valid),
    .held_req   (held_req)
  );

  dwpw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .req    (held_req),
    .emit   (emit),
    .pix    (core_pix),
    .status (status)
  );

  dwpw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_pix  (core_pix),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix)
  );

  // Checks
  `DWPW_ASSERT_NOW(a_emit_in_mem, emit,
    (status.mode == MODE_MEM) && status.byte_phase && held_req.is_data,
    "pixel emitted outside memory write low byte")
  `DWPW_ASSERT_NOW(a_on_panel, out_valid,
    ({1'b0, out_pix.pixel_x} < 9'(PANEL_COLS)) && ({1'b0, out_pix.pixel_y} < 9'(PANEL_ROWS)),
    "pixel off panel")
  `DWPW_ASSERT_NEXT(a_cmd_clears_phase, step && !held_req.is_data, !status.byte_phase,
    "command did not clear pixel pairing")

endmodule
